// ===== sv/fbtm_pkg.sv =====
// Shared types and constants for the FAT12 bad track marker.
// Holds the store geometry, disk geometry constants, item mode codes and the memory request.
// Used by every module of the block; depends on nothing.
package fbtm_pkg;

    localparam int TRACK_COUNT = 80;
    localparam int FAT_BYTES   = 4608;
    localparam int ADDR_W      = $clog2(FAT_BYTES);
    localparam int OFF_W       = 14;
    localparam int LOG_W       = 13;
    localparam int CNT_W       = 5;

    localparam logic [CNT_W-1:0] SPT_525 = 5'd15;
    localparam logic [CNT_W-1:0] SPT_35  = 5'd18;
    localparam logic [OFF_W-1:0] DS_525  = 14'h1d;
    localparam logic [OFF_W-1:0] DS_35   = 14'h21;

    localparam logic [7:0] MEDIA_525 = 8'hF9;
    localparam logic [7:0] MEDIA_35  = 8'hF0;
    localparam logic [7:0] BYTE_FILL = 8'hFF;
    localparam logic [7:0] BAD_LOW   = 8'hF7;
    localparam logic [7:0] BAD_HIGH  = 8'h70;
    localparam logic [7:0] NIB_LOW   = 8'h0f;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_MARK  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== sv/fbtm_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on fbtm_pkg for the mode type.
interface fbtm_in_if;
    logic               valid;
    logic               ready;
    fbtm_pkg::t_mode    mode;
    logic               side;
    logic [6:0]         track;
    logic               track_failed;
    logic [12:0]        byte_index;

    modport source (output valid, mode, side, track, track_failed, byte_index, input ready);
    modport sink   (input valid, mode, side, track, track_failed, byte_index, output ready);
endinterface

interface fbtm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, read_data, rejected, input ready);
    modport sink   (input valid, read_data, rejected, output ready);
endinterface

// ===== sv/fat12_bad_track_marker.sv =====
// FAT12 bad track marker top level: disk geometry register, sequencer and table store.
// Each item runs through the sequencer to the result register, one item at a time; a mark
// does a read-modify-write per sector on the store, a clear sweeps the whole table.
// Reset runs a clearing pass over all FAT_BYTES (4608) bytes with no item accepted; geometry is 1.
// Depends on fbtm_pkg, fbtm_if, fbtm_store and fbtm_seq.
module fat12_bad_track_marker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    fbtm_in_if.sink     i_in,
    fbtm_out_if.source  o_out
);

    logic               r_geom_35;
    fbtm_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_35 <= 1'b1;
        end else if (i_cfg_we) begin
            r_geom_35 <= i_cfg_data;
        end
    end

    fbtm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom_35   (r_geom_35),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    fbtm_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== sv/fbtm_store.sv =====
// Byte store holding the FAT12 table: one write port and one registered read port.
// Depends on fbtm_pkg for the depth and the request struct.
module fbtm_store (
    input  logic                i_clk,
    input  fbtm_pkg::t_mem_req  i_req,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_mem [fbtm_pkg::FAT_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// ===== sv/fbtm_seq.sv =====
// Sequencer: clearing sweep, per-sector read-modify-write of packed entries, byte reads.
// Depends on fbtm_pkg and the channel interfaces; drives the store through fbtm_store.
module fbtm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_geom_35,
    fbtm_in_if.sink             i_in,
    fbtm_out_if.source          o_out,
    output fbtm_pkg::t_mem_req  o_mem,
    input  logic [7:0]          i_rdata
);

    typedef enum logic [6:0] {
        S_SWEEP  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_MSETUP = 7'b0000100,
        S_MA     = 7'b0001000,
        S_MB     = 7'b0010000,
        S_RD     = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [fbtm_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [7:0]                      r_media, n_media;
    logic                            r_sweep_item, n_sweep_item;
    logic [7:0]                      r_tr2, n_tr2;
    logic [fbtm_pkg::LOG_W-1:0]      r_log, n_log;
    logic [fbtm_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_ok, n_ok;
    logic                            r_odd, n_odd;
    logic [fbtm_pkg::ADDR_W-1:0]     r_rmw_addr, n_rmw_addr;
    logic [7:0]                      r_pend_data, n_pend_data;
    logic                            r_pend_rej, n_pend_rej;
    logic                            r_out_valid, n_out_valid;
    logic [7:0]                      r_out_data, n_out_data;
    logic                            r_out_rej, n_out_rej;

    logic [fbtm_pkg::CNT_W-1:0]      spt;
    logic [fbtm_pkg::OFF_W-1:0]      first_data;
    logic [fbtm_pkg::OFF_W-1:0]      lg2;
    logic [fbtm_pkg::OFF_W-1:0]      cluster;
    logic [fbtm_pkg::OFF_W-1:0]      off;
    logic [fbtm_pkg::OFF_W-1:0]      off1;
    logic                            out_free;
    logic                            bad_track;

    assign spt        = i_geom_35 ? fbtm_pkg::SPT_35 : fbtm_pkg::SPT_525;
    assign first_data = i_geom_35 ? fbtm_pkg::DS_35 : fbtm_pkg::DS_525;
    assign lg2        = {1'b0, r_log} + fbtm_pkg::OFF_W'(2);
    assign cluster    = lg2 - first_data;
    assign off        = cluster + {1'b0, cluster[fbtm_pkg::OFF_W-1:1]};
    assign off1       = off + fbtm_pkg::OFF_W'(1);
    assign out_free   = !r_out_valid || o_out.ready;
    assign bad_track  = (i_in.track == 7'd0) ||
                        ({1'b0, i_in.track} >= 8'(fbtm_pkg::TRACK_COUNT));

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.rejected  = r_out_rej;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_media      = r_media;
        n_sweep_item = r_sweep_item;
        n_tr2        = r_tr2;
        n_log        = r_log;
        n_cnt        = r_cnt;
        n_ok         = r_ok;
        n_odd        = r_odd;
        n_rmw_addr   = r_rmw_addr;
        n_pend_data  = r_pend_data;
        n_pend_rej   = r_pend_rej;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_data   = r_out_data;
        n_out_rej    = r_out_rej;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_addr;
        o_mem.wdata  = 8'd0;
        o_mem.raddr  = i_in.byte_index[fbtm_pkg::ADDR_W-1:0];

        unique case (r_state)
            S_SWEEP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
                if (r_addr == fbtm_pkg::ADDR_W'(0)) begin
                    o_mem.wdata = r_media;
                end else if (r_addr == fbtm_pkg::ADDR_W'(1) ||
                             r_addr == fbtm_pkg::ADDR_W'(2)) begin
                    o_mem.wdata = fbtm_pkg::BYTE_FILL;
                end else begin
                    o_mem.wdata = 8'd0;
                end
                n_addr = r_addr + fbtm_pkg::ADDR_W'(1);
                if (r_addr == fbtm_pkg::ADDR_W'(fbtm_pkg::FAT_BYTES - 1)) begin
                    n_addr  = '0;
                    n_state = r_sweep_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pend_data = 8'd0;
                    n_pend_rej  = 1'b0;
                    n_state     = S_DONE;
                    unique case (i_in.mode)
                        fbtm_pkg::MODE_CLEAR: begin
                            n_media      = i_geom_35 ? fbtm_pkg::MEDIA_35
                                                     : fbtm_pkg::MEDIA_525;
                            n_addr       = '0;
                            n_sweep_item = 1'b1;
                            n_state      = S_SWEEP;
                        end
                        fbtm_pkg::MODE_MARK: begin
                            if (i_in.track_failed) begin
                                if (bad_track) begin
                                    n_pend_rej = 1'b1;
                                end else begin
                                    n_tr2   = {i_in.track, i_in.side};
                                    n_cnt   = '0;
                                    n_state = S_MSETUP;
                                end
                            end
                        end
                        fbtm_pkg::MODE_READ: begin
                            if ({1'b0, i_in.byte_index} < 14'(fbtm_pkg::FAT_BYTES)) begin
                                n_state = S_RD;
                            end else begin
                                n_pend_rej = 1'b1;
                            end
                        end
                        fbtm_pkg::MODE_NONE: begin
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MSETUP: begin
                n_log   = fbtm_pkg::LOG_W'(spt) * fbtm_pkg::LOG_W'(r_tr2);
                n_state = S_MA;
            end
            S_MA: begin
                n_ok        = (lg2 >= first_data) && (off1 < 14'(fbtm_pkg::FAT_BYTES));
                n_odd       = cluster[0];
                n_rmw_addr  = cluster[0] ? off[fbtm_pkg::ADDR_W-1:0]
                                         : off1[fbtm_pkg::ADDR_W-1:0];
                o_mem.raddr = n_rmw_addr;
                o_mem.we    = n_ok;
                o_mem.waddr = cluster[0] ? off1[fbtm_pkg::ADDR_W-1:0]
                                         : off[fbtm_pkg::ADDR_W-1:0];
                o_mem.wdata = cluster[0] ? fbtm_pkg::BYTE_FILL : fbtm_pkg::BAD_LOW;
                n_state     = S_MB;
            end
            S_MB: begin
                o_mem.we    = r_ok;
                o_mem.waddr = r_rmw_addr;
                o_mem.wdata = r_odd ? ((i_rdata & fbtm_pkg::NIB_LOW) | fbtm_pkg::BAD_HIGH)
                                    : (i_rdata | fbtm_pkg::NIB_LOW);
                n_log = r_log + fbtm_pkg::LOG_W'(1);
                n_cnt = r_cnt + fbtm_pkg::CNT_W'(1);
                if (r_cnt == spt - fbtm_pkg::CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MA;
                end
            end
            S_RD: begin
                n_pend_data = i_rdata;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_pend_data;
                    n_out_rej    = r_pend_rej;
                    n_sweep_item = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_addr       <= '0;
            r_media      <= fbtm_pkg::MEDIA_35;
            r_sweep_item <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_media      <= n_media;
            r_sweep_item <= n_sweep_item;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr2       <= n_tr2;
        r_log       <= n_log;
        r_cnt       <= n_cnt;
        r_ok        <= n_ok;
        r_odd       <= n_odd;
        r_rmw_addr  <= n_rmw_addr;
        r_pend_data <= n_pend_data;
        r_pend_rej  <= n_pend_rej;
        r_out_data  <= n_out_data;
        r_out_rej   <= n_out_rej;
    end

endmodule

// ===== sv/fbtm_checker.sv =====
// Port-level assertions for the FAT12 bad track marker, bound to the top level.
// Depends only on the top level's ports.
module fbtm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data,
    input logic       i_out_rej
);

    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready after reset before the clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_rej |-> i_out_data == 8'd0)
        else $error("rejected item carries nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

endmodule

bind fat12_bad_track_marker fbtm_checker u_fbtm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.read_data),
    .i_out_rej   (o_out.rejected)
);

// ===== test/fbtm_fat_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the FAT12 bad track marker: keeps its own image of the table
// and disk geometry, predicts each result and compares it with the block's output.
// Depends on fbtm_pkg and the channel interfaces in fbtm_if.
module fbtm_fat_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    fbtm_in_if   i_in,
    fbtm_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       rejected;
    } t_fat_result;

    logic [7:0]  fat_image [fbtm_pkg::FAT_BYTES];
    logic        geom_35;
    t_fat_result expected_q [$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void flag_fail(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: mismatch, %s", $time, msg);
        end
    endfunction

    function automatic void wipe_fat();
        for (int i = 0; i < fbtm_pkg::FAT_BYTES; i++) begin
            fat_image[i] = 8'h00;
        end
        fat_image[0] = geom_35 ? fbtm_pkg::MEDIA_35 : fbtm_pkg::MEDIA_525;
        fat_image[1] = fbtm_pkg::BYTE_FILL;
        fat_image[2] = fbtm_pkg::BYTE_FILL;
    endfunction

    function automatic void set_bad_cluster(int unsigned cluster);
        int unsigned off;
        off = cluster + (cluster >> 1);
        if (off + 1 >= fbtm_pkg::FAT_BYTES) begin
            return;
        end
        if (cluster[0] == 1'b0) begin
            fat_image[off]     = fbtm_pkg::BAD_LOW;
            fat_image[off + 1] = fat_image[off + 1] | fbtm_pkg::NIB_LOW;
        end else begin
            fat_image[off]     = (fat_image[off] & fbtm_pkg::NIB_LOW) | fbtm_pkg::BAD_HIGH;
            fat_image[off + 1] = fbtm_pkg::BYTE_FILL;
        end
    endfunction

    function automatic logic mark_bad_track(logic [6:0] track, logic side);
        int unsigned spt;
        int unsigned first_data;
        int unsigned lsec;
        int unsigned s;
        spt        = geom_35 ? fbtm_pkg::SPT_35 : fbtm_pkg::SPT_525;
        first_data = geom_35 ? fbtm_pkg::DS_35 : fbtm_pkg::DS_525;
        if (track == 0 || track >= fbtm_pkg::TRACK_COUNT) begin
            return 1'b1;
        end
        for (s = 1; s <= spt; s++) begin
            lsec = spt * (2 * int'(track) + int'(side)) + s - 1;
            if (lsec + 2 >= first_data) begin
                set_bad_cluster(lsec + 2 - first_data);
            end
        end
        return 1'b0;
    endfunction

    function automatic t_fat_result predict_fat_item(fbtm_pkg::t_mode mode, logic side,
                                                     logic [6:0] track, logic failed,
                                                     logic [12:0] idx);
        t_fat_result r;
        r = '0;
        case (mode)
            fbtm_pkg::MODE_CLEAR: begin
                wipe_fat();
            end
            fbtm_pkg::MODE_MARK: begin
                if (failed) begin
                    r.rejected = mark_bad_track(track, side);
                end
            end
            fbtm_pkg::MODE_READ: begin
                if (idx < fbtm_pkg::FAT_BYTES) begin
                    r.read_data = fat_image[idx];
                end else begin
                    r.rejected = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fat_result seen;
        t_fat_result want;
        if (!i_rst_n) begin
            geom_35 = 1'b1;
            wipe_fat();
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                geom_35 = i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                expected_q.push_back(predict_fat_item(i_in.mode, i_in.side, i_in.track,
                                                      i_in.track_failed, i_in.byte_index));
            end
            if (i_out.valid && i_out.ready) begin
                seen.read_data = i_out.read_data;
                seen.rejected  = i_out.rejected;
                if (expected_q.size() == 0) begin
                    flag_fail($sformatf("result with none pending: read_data %02h rejected %0b",
                                        seen.read_data, seen.rejected));
                end else begin
                    want = expected_q.pop_front();
                    if (seen.read_data !== want.read_data) begin
                        flag_fail($sformatf("read_data expected %02h, got %02h",
                                            want.read_data, seen.read_data));
                    end
                    if (seen.rejected !== want.rejected) begin
                        flag_fail($sformatf("rejected expected %0b, got %0b",
                                            want.rejected, seen.rejected));
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_fat12_bad_track_marker.sv =====
`timescale 1ns / 1ps
// Testbench top for the FAT12 bad track marker: clock, reset, directed and random items,
// geometry writes, output back-pressure and the verdict.
// Depends on fbtm_pkg, fbtm_if, the block itself and fbtm_fat_checker.
module tb_fat12_bad_track_marker;

    localparam int RUN_ITEMS  = 800;
    localparam int PHASES     = 8;
    localparam int IDLE_PCT   = 27;
    localparam int HOLD_TICKS = 400;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_data;
    logic quiet;
    int   hold_reqs;
    int   fail_count;
    int   pending;

    fbtm_in_if  item_ch ();
    fbtm_out_if result_ch ();

    fat12_bad_track_marker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (item_ch),
        .o_out      (result_ch)
    );

    fbtm_fat_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in         (item_ch),
        .i_out        (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic offer(input fbtm_pkg::t_mode m, input logic sd, input logic [6:0] trk,
                         input logic bad, input logic [12:0] idx);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid        <= 1'b0;
            item_ch.mode         <= fbtm_pkg::t_mode'($urandom_range(3));
            item_ch.side         <= 1'($urandom);
            item_ch.track        <= 7'($urandom);
            item_ch.track_failed <= 1'($urandom);
            item_ch.byte_index   <= 13'($urandom);
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= m;
        item_ch.side         <= sd;
        item_ch.track        <= trk;
        item_ch.track_failed <= bad;
        item_ch.byte_index   <= idx;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_geometry(input logic is_35);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= is_35;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic read_byte(input logic [12:0] idx);
        offer(fbtm_pkg::MODE_READ, 1'($urandom), 7'($urandom), 1'($urandom), idx);
    endtask

    task automatic mark_track(input logic [6:0] trk, input logic sd, input logic bad);
        offer(fbtm_pkg::MODE_MARK, sd, trk, bad, 13'($urandom));
    endtask

    task automatic random_item();
        int          pick;
        logic [6:0]  trk;
        logic        bad;
        logic [12:0] idx;
        pick = $urandom_range(99);
        if (pick < 4) begin
            offer(fbtm_pkg::MODE_CLEAR, 1'($urandom), 7'($urandom), 1'($urandom),
                  13'($urandom));
        end else if (pick < 8) begin
            offer(fbtm_pkg::MODE_NONE, 1'($urandom), 7'($urandom), 1'($urandom),
                  13'($urandom));
        end else if (pick < 52) begin
            trk = 7'($urandom_range(1, fbtm_pkg::TRACK_COUNT - 1));
            if ($urandom_range(19) == 0) begin
                trk = 7'($urandom_range(127));
            end
            bad = ($urandom_range(9) != 0);
            mark_track(trk, 1'($urandom), bad);
        end else begin
            idx = 13'($urandom_range(fbtm_pkg::FAT_BYTES - 1));
            if ($urandom_range(15) == 0) begin
                idx = 13'($urandom_range(8191));
            end
            read_byte(idx);
        end
    endtask

    initial begin
        int unsigned done_reqs;
        int          hold_left;
        done_reqs = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && done_reqs != hold_reqs) begin
                done_reqs++;
                hold_left = HOLD_TICKS;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_data             <= 1'b0;
        quiet                <= 1'b0;
        hold_reqs            <= 0;
        item_ch.valid        <= 1'b0;
        item_ch.mode         <= fbtm_pkg::MODE_NONE;
        item_ch.side         <= 1'b0;
        item_ch.track        <= '0;
        item_ch.track_failed <= 1'b0;
        item_ch.byte_index   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Header bytes, store edges, out-of-range reads and track marks at the reset geometry.
        read_byte(13'd0);
        read_byte(13'd1);
        read_byte(13'd2);
        read_byte(13'd3);
        read_byte(13'(fbtm_pkg::FAT_BYTES - 1));
        read_byte(13'(fbtm_pkg::FAT_BYTES));
        read_byte(13'd8191);
        offer(fbtm_pkg::MODE_NONE, 1'b1, 7'd127, 1'b1, 13'd8191);
        mark_track(7'd0, 1'b0, 1'b1);
        mark_track(7'd0, 1'b1, 1'b0);
        mark_track(7'(fbtm_pkg::TRACK_COUNT), 1'b1, 1'b1);
        mark_track(7'd127, 1'b0, 1'b1);
        mark_track(7'd1, 1'b0, 1'b1);
        mark_track(7'(fbtm_pkg::TRACK_COUNT - 1), 1'b1, 1'b1);
        mark_track(7'd5, 1'b1, 1'b0);
        read_byte(13'd7);
        read_byte(13'd8);
        read_byte(13'd33);
        read_byte(13'd4272);

        // A geometry change must not touch the table until the next clear.
        set_geometry(1'b0);
        read_byte(13'd0);
        mark_track(7'd1, 1'b1, 1'b1);
        read_byte(13'd27);
        read_byte(13'd48);
        offer(fbtm_pkg::MODE_CLEAR, 1'b0, 7'd0, 1'b0, 13'd0);
        read_byte(13'd0);
        read_byte(13'd27);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                set_geometry(1'(p));
            end else begin
                set_geometry(1'($urandom));
            end
            quiet <= (p == 2);
            if (p == 5) begin
                hold_reqs <= hold_reqs + 1;
            end
            if ($urandom_range(1) == 0) begin
                offer(fbtm_pkg::MODE_CLEAR, 1'b0, 7'd0, 1'b0, 13'd0);
            end
            for (int n = 0; n < RUN_ITEMS / PHASES; n++) begin
                random_item();
            end
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_fat12_bad_track_marker OK");
        end else begin
            $display("tb_fat12_bad_track_marker NOT OK");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_fat12_bad_track_marker NOT OK");
        $finish;
    end

endmodule
